[rtl/drbm_pkg.sv]
package drbm_pkg;

    localparam longint unsigned MAIN_BYTES  = 64'd65536;
    localparam longint unsigned VIDEO_BASE  = 64'd2684354560;
    localparam longint unsigned VIDEO_BYTES = 64'd65536;

    // Each store is four byte lanes; one row holds one byte of each lane.
    localparam int MAIN_ROWS  = int'((MAIN_BYTES + 64'd3) / 64'd4);
    localparam int VIDEO_ROWS = int'((VIDEO_BYTES + 64'd3) / 64'd4);
    localparam int CLR_ROWS   = (MAIN_ROWS > VIDEO_ROWS) ? MAIN_ROWS : VIDEO_ROWS;

    localparam int MAIN_AW  = (MAIN_ROWS > 1) ? $clog2(MAIN_ROWS) : 1;
    localparam int VIDEO_AW = (VIDEO_ROWS > 1) ? $clog2(VIDEO_ROWS) : 1;
    localparam int CLR_W    = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;

    localparam longint unsigned MAX_BYTES =
        (MAIN_BYTES > VIDEO_BYTES) ? MAIN_BYTES : VIDEO_BYTES;
    localparam int OFF_W = $clog2(MAX_BYTES);
    localparam int ROW_W = (OFF_W > 3) ? OFF_W - 2 : 1;

    localparam logic [32:0] VIDEO_LO  = 33'(VIDEO_BASE);
    localparam logic [32:0] VIDEO_HI  = 33'(VIDEO_BASE) + 33'(VIDEO_BYTES);
    localparam logic [32:0] MAIN_HI   = 33'(MAIN_BYTES);
    localparam logic [OFF_W-1:0] VIDEO_OFF = OFF_W'(VIDEO_BASE);

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        out_of_range;
        logic        vram_dirty;
    } out_t;

    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic                  sel_main;
        logic                  sel_video;
        logic                  err;
        logic [1:0]            lane0;
        logic [1:0]            size;
        logic [3:0]            wmask;
        logic [3:0][7:0]       wbytes;
        logic [3:0][ROW_W-1:0] row;
    } dec_t;

    typedef struct packed {
        logic       rd;
        logic       err;
        logic       sel_video;
        logic [1:0] lane0;
        logic [1:0] size;
        logic       dirty;
    } meta_t;

endpackage

[rtl/dual_region_byte_memory_top.sv]
// Byte-addressed memory with a main store and a video store behind one
// load/store port.
// Input channel (s_valid, s_ready, s_data): one read, write or dirty-flag
// clear per transfer; reads and writes move 1, 2 or 4 little-endian bytes
// at any alignment. Output channel (m_valid, m_ready, m_data): one result
// per input, in order, with the read data, the out-of-range flag and the
// video dirty flag after that item.
// Each result passes through the RAM read stage and the output register.
// Throughput: one item per cycle unless the output stalls; each store is
// four byte-lane RAMs with one port each, so an unaligned access still
// touches each lane at most once. Reset: both stores are zeroed by a
// clearing pass over CLR_ROWS rows (16384 at the default sizes), one row
// of all lanes per cycle; s_ready stays low until it ends.
// Stall: while m_ready is low the result holds in the output register, one
// more item waits in the RAM read stage, and s_ready drops after that.
module dual_region_byte_memory_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  drbm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output drbm_pkg::out_t m_data
);
    import drbm_pkg::*;

    dec_t             dec;
    logic             accept;
    logic             adv;
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_idx_reg;
    logic             dirty_reg;
    logic             dirty_next;
    logic             p1_valid_reg;
    meta_t            p1_meta_reg;
    meta_t            meta_next;
    logic             m_valid_reg;
    out_t             m_data_reg;
    out_t             out_next;
    logic             main_clr_en;
    logic             video_clr_en;
    logic [3:0][7:0]  main_rd;
    logic [3:0][7:0]  video_rd;
    logic [31:0]      word;
    logic [63:0]      rdbl;
    logic [31:0]      size_mask;

    drbm_decode u_decode (
        .req (s_data),
        .dec (dec)
    );

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !clr_busy_reg && (!p1_valid_reg || adv);
    assign accept  = s_valid && s_ready;

    assign main_clr_en  = {1'b0, clr_idx_reg} < (CLR_W + 1)'(MAIN_ROWS);
    assign video_clr_en = {1'b0, clr_idx_reg} < (CLR_W + 1)'(VIDEO_ROWS);

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic                en_main;
        logic                en_video;
        logic [MAIN_AW-1:0]  addr_main;
        logic [VIDEO_AW-1:0] addr_video;
        logic [7:0]          wd;

        assign en_main  = clr_busy_reg ? main_clr_en
                        : (accept && dec.sel_main && (dec.rd || dec.wmask[l]));
        assign en_video = clr_busy_reg ? video_clr_en
                        : (accept && dec.sel_video && (dec.rd || dec.wmask[l]));
        assign addr_main  = clr_busy_reg ? clr_idx_reg[MAIN_AW-1:0]
                                         : dec.row[l][MAIN_AW-1:0];
        assign addr_video = clr_busy_reg ? clr_idx_reg[VIDEO_AW-1:0]
                                         : dec.row[l][VIDEO_AW-1:0];
        assign wd = clr_busy_reg ? 8'h00 : dec.wbytes[l];

        drbm_ram #(
            .DEPTH (MAIN_ROWS),
            .WIDTH (8)
        ) u_main (
            .aclk  (aclk),
            .en    (en_main),
            .we    (clr_busy_reg || dec.wr),
            .addr  (addr_main),
            .wdata (wd),
            .rdata (main_rd[l])
        );

        drbm_ram #(
            .DEPTH (VIDEO_ROWS),
            .WIDTH (8)
        ) u_video (
            .aclk  (aclk),
            .en    (en_video),
            .we    (clr_busy_reg || dec.wr),
            .addr  (addr_video),
            .wdata (wd),
            .rdata (video_rd[l])
        );
    end

    always_comb begin
        dirty_next = dirty_reg;
        priority if (s_data.func == FUNC_CLEAR) begin
            dirty_next = 1'b0;
        end else if (dec.wr && dec.sel_video) begin
            dirty_next = 1'b1;
        end
    end

    always_comb begin
        meta_next.rd        = dec.rd;
        meta_next.err       = dec.err;
        meta_next.sel_video = dec.sel_video;
        meta_next.lane0     = dec.lane0;
        meta_next.size      = dec.size;
        meta_next.dirty     = dirty_next;
    end

    // Rotate the lane bytes so the first byte accessed lands in bits 7:0.
    assign word = p1_meta_reg.sel_video ? video_rd : main_rd;
    assign rdbl = {word, word} >> {p1_meta_reg.lane0, 3'b000};

    always_comb begin
        unique case (p1_meta_reg.size)
            SIZE_BYTE: size_mask = {24'h0, BYTE_MASK};
            SIZE_HALF: size_mask = {16'h0, BYTE_MASK, BYTE_MASK};
            default:   size_mask = {4{BYTE_MASK}};
        endcase
    end

    always_comb begin
        out_next.read_data    = (p1_meta_reg.rd && !p1_meta_reg.err)
                              ? (rdbl[31:0] & size_mask) : 32'h0;
        out_next.out_of_range = p1_meta_reg.err;
        out_next.vram_dirty   = p1_meta_reg.dirty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            dirty_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == CLR_W'(CLR_ROWS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept) begin
                dirty_reg <= dirty_next;
            end
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_meta_reg <= meta_next;
        end
        if (adv && p1_valid_reg) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/drbm_ram.sv]
module drbm_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

[rtl/drbm_decode.sv]
module drbm_decode (
    input  drbm_pkg::in_t  req,
    output drbm_pkg::dec_t dec
);
    import drbm_pkg::*;

    logic [2:0]       nbytes;
    logic [32:0]      end_addr;
    logic             rw;
    logic             vid_fit;
    logic             main_fit;
    logic [OFF_W-1:0] offset;
    logic [ROW_W-1:0] row_base;
    logic [3:0]       base_mask;
    logic [7:0]       mask_dbl;
    logic [4:0]       shamt;
    logic [63:0]      wdbl;

    always_comb begin
        unique case (req.access_size)
            SIZE_BYTE: begin
                nbytes    = 3'd1;
                base_mask = 4'b0001;
            end
            SIZE_HALF: begin
                nbytes    = 3'd2;
                base_mask = 4'b0011;
            end
            default: begin
                nbytes    = 3'd4;
                base_mask = 4'b1111;
            end
        endcase
    end

    assign end_addr = {1'b0, req.address} + 33'(nbytes);
    assign rw       = (req.func == FUNC_READ) || (req.func == FUNC_WRITE);
    assign vid_fit  = ({1'b0, req.address} >= VIDEO_LO) && (end_addr <= VIDEO_HI);
    assign main_fit = end_addr <= MAIN_HI;

    // Only one store is selected, so one offset serves both.
    assign offset   = vid_fit ? (req.address[OFF_W-1:0] - VIDEO_OFF)
                              : req.address[OFF_W-1:0];
    assign row_base = ROW_W'(offset >> 2);

    assign mask_dbl = {base_mask, base_mask} << offset[1:0];
    assign shamt    = {offset[1:0], 3'b000};
    assign wdbl     = {req.write_data, req.write_data} << shamt;

    always_comb begin
        dec.rd        = req.func == FUNC_READ;
        dec.wr        = req.func == FUNC_WRITE;
        dec.sel_video = rw && vid_fit;
        dec.sel_main  = rw && !vid_fit && main_fit;
        dec.err       = rw && !vid_fit && !main_fit;
        dec.lane0     = offset[1:0];
        dec.size      = req.access_size;
        dec.wmask     = mask_dbl[7:4];
        dec.wbytes    = wdbl[63:32];
        for (int l = 0; l < 4; l++) begin
            // Lanes below the first lane wrap into the next row.
            dec.row[l] = row_base + ROW_W'((2'(l) < offset[1:0]) ? 1 : 0);
        end
    end

endmodule

[rtl/drbm_checker.sv]
module drbm_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input drbm_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input drbm_pkg::out_t m_data
);
    import drbm_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_of_range |-> m_data.read_data == 32'h0)
        else $error("out-of-range result carries read data");

    // The clearing pass keeps the input closed right after reset.
    a_clear_pass: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open during clearing pass");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind dual_region_byte_memory_top drbm_checker u_checker (.*);

[verif/tb_dual_region_byte_memory_top.sv]
`timescale 1ns / 1ps

module tb_dual_region_byte_memory_top;
    import drbm_pkg::*;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam logic [1:0] SIZE_WORD    = 2'd2;
    localparam logic [1:0] SIZE_RSVD    = 2'd3;

    localparam logic [31:0] MAIN_TOP  = 32'(MAIN_BYTES);
    localparam logic [31:0] VID_BASE  = 32'(VIDEO_BASE);
    localparam logic [31:0] VID_TOP   = 32'(VIDEO_BASE + VIDEO_BYTES);
    localparam int          MAIN_SZ   = int'(MAIN_BYTES);
    localparam int          VIDEO_SZ  = int'(VIDEO_BYTES);

    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 60000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Shadow copy of both stores and the dirty flag
    bit [7:0] main_shadow  [0:MAIN_SZ-1];
    bit [7:0] video_shadow [0:VIDEO_SZ-1];
    bit       dirty_shadow;

    out_t expected_results [$];
    int   errors        = 0;
    bit   tx_gaps_on    = 1'b1;
    bit   rx_gaps_on    = 1'b1;
    int   hold_requests = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;

    dual_region_byte_memory_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Apply one access to the shadow stores and return the result it should produce.
    task automatic compute_access_result(input in_t item, output out_t res);
        logic [32:0] first;
        logic [32:0] stop;
        logic [32:0] offset;
        int          nbytes;
        bit          to_video;
        bit          to_main;
        res = '0;
        case (item.func)
            FUNC_CLEAR: dirty_shadow = 1'b0;
            FUNC_READ, FUNC_WRITE: begin
                nbytes   = (item.access_size == SIZE_BYTE) ? 1 :
                           (item.access_size == SIZE_HALF) ? 2 : 4;
                first    = {1'b0, item.address};
                stop     = first + 33'(nbytes);
                to_video = (first >= VIDEO_LO) && (stop <= VIDEO_HI);
                to_main  = !to_video && (stop <= MAIN_HI);
                offset   = to_video ? first - VIDEO_LO : first;
                if (!to_video && !to_main) begin
                    res.out_of_range = 1'b1;
                end else begin
                    for (int i = 0; i < nbytes; i++) begin
                        if (item.func == FUNC_READ) begin
                            res.read_data[8*i +: 8] = to_video ?
                                video_shadow[int'(offset) + i] : main_shadow[int'(offset) + i];
                        end else if (to_video) begin
                            video_shadow[int'(offset) + i] = item.write_data[8*i +: 8];
                        end else begin
                            main_shadow[int'(offset) + i] = item.write_data[8*i +: 8];
                        end
                    end
                    if (item.func == FUNC_WRITE && to_video) dirty_shadow = 1'b1;
                end
            end
            default: ;
        endcase
        res.vram_dirty = dirty_shadow;
    endtask

    task automatic issue_access(input logic [1:0] func, input logic [1:0] size,
                                input logic [31:0] addr, input logic [31:0] wdata);
        in_t  item;
        out_t res;
        item = '{func: func, access_size: size, address: addr, write_data: wdata};
        while (tx_gaps_on && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        compute_access_result(item, res);
        expected_results.push_back(res);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    function automatic logic [31:0] random_address();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return 32'($urandom_range(0, 63));
        if (pick < 50) return 32'($urandom_range(0, MAIN_SZ - 1));
        if (pick < 70) return VID_BASE + 32'($urandom_range(0, 63));
        if (pick < 85) return VID_BASE + 32'($urandom_range(0, VIDEO_SZ - 1));
        if (pick < 93) begin
            case ($urandom_range(0, 3))
                0:       return MAIN_TOP - 32'($urandom_range(1, 5));
                1:       return VID_BASE + 32'($urandom_range(0, 4)) - 32'd2;
                2:       return VID_TOP - 32'($urandom_range(1, 5));
                default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_random_traffic(input int count);
        int unsigned sel;
        logic [1:0]  func;
        for (int i = 0; i < count; i++) begin
            sel  = $urandom_range(0, 99);
            func = (sel < 4) ? FUNC_CLEAR : (sel < 6) ? FUNC_IGNORED :
                   (sel < 50) ? FUNC_WRITE : FUNC_READ;
            issue_access(func, 2'($urandom_range(0, 3)), random_address(), $urandom);
        end
    endtask

    task automatic test_main_store();
        issue_access(FUNC_READ,  SIZE_WORD, 32'd0, 32'd0);
        issue_access(FUNC_WRITE, SIZE_WORD, 32'd0, 32'h0403_0201);
        issue_access(FUNC_READ,  SIZE_HALF, 32'd1, 32'd0);
        issue_access(FUNC_READ,  SIZE_BYTE, 32'd3, 32'd0);
        issue_access(FUNC_WRITE, SIZE_WORD, MAIN_TOP - 32'd4, 32'hFFFF_FFFF);
        issue_access(FUNC_READ,  SIZE_RSVD, MAIN_TOP - 32'd4, 32'd0);
        issue_access(FUNC_READ,  SIZE_HALF, MAIN_TOP - 32'd2, 32'd0);
        issue_access(FUNC_READ,  SIZE_HALF, MAIN_TOP - 32'd1, 32'd0);
        // straddles the top of main: must not write anything
        issue_access(FUNC_WRITE, SIZE_WORD, MAIN_TOP - 32'd3, 32'd0);
        issue_access(FUNC_READ,  SIZE_WORD, MAIN_TOP - 32'd4, 32'd0);
    endtask

    task automatic test_video_store();
        issue_access(FUNC_WRITE,   SIZE_BYTE, VID_BASE, 32'hFFFF_FFA5);
        issue_access(FUNC_READ,    SIZE_WORD, VID_BASE, 32'd0);
        issue_access(FUNC_CLEAR,   SIZE_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_access(FUNC_WRITE,   SIZE_HALF, VID_TOP - 32'd2, 32'h1234_BEEF);
        issue_access(FUNC_READ,    SIZE_WORD, VID_TOP - 32'd4, 32'd0);
        issue_access(FUNC_WRITE,   SIZE_WORD, VID_TOP - 32'd1, 32'h5555_5555);
        issue_access(FUNC_CLEAR,   SIZE_BYTE, 32'd0, 32'd0);
        issue_access(FUNC_WRITE,   SIZE_WORD, VID_TOP - 32'd2, 32'hAAAA_AAAA);
        issue_access(FUNC_READ,    SIZE_HALF, VID_BASE - 32'd1, 32'd0);
        // no wrap past the top of the address space
        issue_access(FUNC_READ,    SIZE_WORD, 32'hFFFF_FFFF, 32'd0);
        issue_access(FUNC_READ,    SIZE_BYTE, 32'hFFFF_FFFF, 32'd0);
        issue_access(FUNC_IGNORED, SIZE_WORD, VID_BASE, 32'h0BAD_F00D);
        issue_access(FUNC_READ,    SIZE_RSVD, VID_BASE, 32'd0);
        issue_access(FUNC_WRITE,   SIZE_BYTE, 32'd7, 32'h0000_0077);
    endtask

    // Stall the receiver long enough for the block to back up into its input.
    task automatic test_backpressure();
        hold_requests++;
        test_random_traffic(60);
        wait_for_results();
    endtask

    task automatic test_streaming();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        test_random_traffic(300);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing pending: %h", $time, m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h got %h",
                             $time, want.read_data, m_data.read_data);
                    errors++;
                end
                if (m_data.out_of_range !== want.out_of_range) begin
                    $display("%0t: out_of_range expected %b got %b",
                             $time, want.out_of_range, m_data.out_of_range);
                    errors++;
                end
                if (m_data.vram_dirty !== want.vram_dirty) begin
                    $display("%0t: vram_dirty expected %b got %b",
                             $time, want.vram_dirty, m_data.vram_dirty);
                    errors++;
                end
            end
        end
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_gaps_on && $urandom_range(0, 99) < 30);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[dual_region_byte_memory_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_main_store();
        wait_for_results();
        test_video_store();
        wait_for_results();
        test_random_traffic(1370);
        wait_for_results();
        test_backpressure();
        test_streaming();
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[dual_region_byte_memory_top] OK");
        end else begin
            $display("[dual_region_byte_memory_top] ERROR");
        end
        $finish;
    end

endmodule
